/* rtl/dtq_pkg.sv */
// dtq_pkg: shared constants, item structs and sequencer states for the
// deadline timer queue. No dependencies.

package dtq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int DL_W        = 48;
    localparam int TASK_W      = 16;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_CHECK    = 1'b1;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_NOFREE = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [DL_W-1:0]   deadline_us;
        logic [TASK_W-1:0] task_handle;
        logic [DL_W-1:0]   now_us;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [TASK_W-1:0] task_out;
        logic [DL_W-1:0]   deadline_out;
        logic              rearm;
        logic              pending;
        logic              last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FINISH
    } state_t;

endpackage

/* rtl/deadline_timer_queue_unit.sv */
// deadline_timer_queue_unit: bounded timer table with collision bumping and
// earliest-first expiry, one slot scanned per cycle. Depends on dtq_pkg.
//
//   channel | ports                    | moves
//   --------+--------------------------+-------------------------------------
//   input   | s_valid, s_ready, s_item | schedule or check request
//   result  | m_valid, m_ready, m_item | answer, expired timer, next deadline
//
// Every pass reads the slot memory one entry per cycle.
// Schedule: one pass and one result, with no new accept until back in idle.
// Check: one pass per expired timer plus one for the closing result.
// s_ready is high only when idle; a result waiting in the output register
// stalls the sequencer only when the next result is due.
// Reset clears the valid bits and control; slot contents need no clearing.

module deadline_timer_queue_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtq_pkg::in_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output dtq_pkg::out_item_t m_item
);

    typedef struct packed {
        logic [dtq_pkg::DL_W-1:0]   dl;
        logic [dtq_pkg::TASK_W-1:0] tsk;
    } slot_entry_t;

    localparam logic [dtq_pkg::SLOT_IDX_W-1:0] LAST_IDX =
        dtq_pkg::SLOT_IDX_W'(dtq_pkg::TIMER_SLOTS - 1);

    // Lowest clear bit of the collision mask, i.e. the bump count.
    function automatic logic [dtq_pkg::SLOT_IDX_W-1:0] first_zero(
        input logic [dtq_pkg::TIMER_SLOTS-1:0] mask
    );
        logic [dtq_pkg::SLOT_IDX_W-1:0] pos;
        logic                           found;
        pos   = '0;
        found = 1'b0;
        for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++) begin
            if (!found && !mask[i]) begin
                pos   = dtq_pkg::SLOT_IDX_W'(i);
                found = 1'b1;
            end
        end
        return pos;
    endfunction

    slot_entry_t slot_mem [dtq_pkg::TIMER_SLOTS];

    dtq_pkg::state_t                  state_reg, state_next;
    logic                             op_reg, op_next;
    logic [dtq_pkg::DL_W-1:0]         req_dl_reg, req_dl_next;
    logic [dtq_pkg::TASK_W-1:0]       req_task_reg, req_task_next;
    logic [dtq_pkg::DL_W-1:0]         now_reg, now_next;
    logic [dtq_pkg::SLOT_IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                             data_vld_reg, data_vld_next;
    logic [dtq_pkg::SLOT_IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    slot_entry_t                      rd_entry_reg;
    logic                             free_found_reg, free_found_next;
    logic [dtq_pkg::SLOT_IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic                             any_reg, any_next;
    logic [dtq_pkg::DL_W-1:0]         min_dl_reg, min_dl_next;
    logic [dtq_pkg::TASK_W-1:0]       min_task_reg, min_task_next;
    logic [dtq_pkg::SLOT_IDX_W-1:0]   min_idx_reg, min_idx_next;
    logic [dtq_pkg::TIMER_SLOTS-1:0]  occ_mask_reg, occ_mask_next;
    logic [dtq_pkg::TIMER_SLOTS-1:0]  valid_reg, valid_next;
    logic                             m_valid_reg;
    dtq_pkg::out_item_t               m_item_reg;

    logic                             rd_en;
    logic                             wr_en;
    slot_entry_t                      wr_entry;
    logic                             load_out;
    logic                             out_free;
    dtq_pkg::out_item_t               out_next;
    logic [dtq_pkg::DL_W:0]           diff;
    logic [dtq_pkg::DL_W:0]           bumped;
    logic                             cur_valid;

    assign s_ready  = (state_reg == dtq_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign cur_valid = valid_reg[rd_idx_reg];
    assign diff   = {1'b0, rd_entry_reg.dl} - {1'b0, req_dl_reg};
    assign bumped = {1'b0, req_dl_reg} + (dtq_pkg::DL_W + 1)'(first_zero(occ_mask_reg));

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_dl_next     = req_dl_reg;
        req_task_next   = req_task_reg;
        now_next        = now_reg;
        scan_idx_next   = scan_idx_reg;
        data_vld_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_next        = any_reg;
        min_dl_next     = min_dl_reg;
        min_task_next   = min_task_reg;
        min_idx_next    = min_idx_reg;
        occ_mask_next   = occ_mask_reg;
        valid_next      = valid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_entry        = '{dl: bumped[dtq_pkg::DL_W-1:0], tsk: req_task_reg};
        load_out        = 1'b0;
        out_next        = '0;

        // Fold the entry read last cycle into the pass results.
        if (data_vld_reg) begin
            if (!cur_valid) begin
                if (!free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
            end else begin
                if (!any_reg || rd_entry_reg.dl < min_dl_reg) begin
                    min_dl_next   = rd_entry_reg.dl;
                    min_task_next = rd_entry_reg.tsk;
                    min_idx_next  = rd_idx_reg;
                end
                any_next = 1'b1;
                if (diff < (dtq_pkg::DL_W + 1)'(dtq_pkg::TIMER_SLOTS)) begin
                    occ_mask_next[diff[dtq_pkg::SLOT_IDX_W-1:0]] = 1'b1;
                end
            end
        end

        case (state_reg)
            dtq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    op_next         = s_item.operation;
                    req_dl_next     = s_item.deadline_us;
                    req_task_next   = s_item.task_handle;
                    now_next        = s_item.now_us;
                    scan_idx_next   = '0;
                    free_found_next = 1'b0;
                    any_next        = 1'b0;
                    occ_mask_next   = '0;
                    state_next      = dtq_pkg::ST_SCAN;
                end
            end
            dtq_pkg::ST_SCAN: begin
                rd_en         = 1'b1;
                rd_idx_next   = scan_idx_reg;
                data_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = dtq_pkg::ST_TAIL;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            dtq_pkg::ST_TAIL: begin
                state_next = dtq_pkg::ST_FINISH;
            end
            dtq_pkg::ST_FINISH: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (op_reg == dtq_pkg::OP_SCHEDULE) begin
                        out_next.kind = dtq_pkg::KIND_SCHED;
                        out_next.last = 1'b1;
                        if (!free_found_reg) begin
                            out_next.status       = dtq_pkg::STATUS_FULL;
                            out_next.deadline_out = req_dl_reg;
                        end else if (bumped[dtq_pkg::DL_W]) begin
                            // bumping ran past the largest deadline: drop
                            out_next.status       = dtq_pkg::STATUS_NOFREE;
                            out_next.deadline_out = req_dl_reg;
                        end else begin
                            wr_en                     = 1'b1;
                            valid_next[free_idx_reg]  = 1'b1;
                            out_next.status           = dtq_pkg::STATUS_OK;
                            out_next.deadline_out     = bumped[dtq_pkg::DL_W-1:0];
                            out_next.rearm            = !any_reg ||
                                (bumped[dtq_pkg::DL_W-1:0] < min_dl_reg);
                        end
                        state_next = dtq_pkg::ST_IDLE;
                    end else if (any_reg && min_dl_reg <= now_reg) begin
                        // drop the earliest due timer and rescan
                        valid_next[min_idx_reg] = 1'b0;
                        out_next.kind           = dtq_pkg::KIND_EXPIRE;
                        out_next.status         = dtq_pkg::STATUS_OK;
                        out_next.task_out       = min_task_reg;
                        out_next.deadline_out   = min_dl_reg;
                        scan_idx_next           = '0;
                        free_found_next         = 1'b0;
                        any_next                = 1'b0;
                        occ_mask_next           = '0;
                        state_next              = dtq_pkg::ST_SCAN;
                    end else begin
                        out_next.kind         = dtq_pkg::KIND_CLOSE;
                        out_next.status       = dtq_pkg::STATUS_OK;
                        out_next.deadline_out = any_reg ? min_dl_reg : '0;
                        out_next.rearm        = any_reg;
                        out_next.last         = 1'b1;
                        state_next            = dtq_pkg::ST_IDLE;
                    end
                    out_next.pending = |valid_next;
                end
            end
            default: begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dtq_pkg::ST_IDLE;
            data_vld_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            data_vld_reg <= data_vld_next;
            valid_reg    <= valid_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        req_dl_reg     <= req_dl_next;
        req_task_reg   <= req_task_next;
        now_reg        <= now_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        any_reg        <= any_next;
        min_dl_reg     <= min_dl_next;
        min_task_reg   <= min_task_next;
        min_idx_reg    <= min_idx_next;
        occ_mask_reg   <= occ_mask_next;
        if (load_out) begin
            m_item_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[free_idx_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= slot_mem[scan_idx_reg];
        end
    end

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == dtq_pkg::ST_SCAN)
        else $error("accepted item did not start a scan");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && out_next.last |=> state_reg == dtq_pkg::ST_IDLE)
        else $error("sequencer busy after final result");

    a_sched_adds_one: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && out_next.kind == dtq_pkg::KIND_SCHED &&
        out_next.status == dtq_pkg::STATUS_OK
        |=> $countones(valid_reg) == $countones($past(valid_reg)) + 1)
        else $error("accepted timer did not occupy exactly one slot");

    a_expire_drops_one: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && out_next.kind == dtq_pkg::KIND_EXPIRE
        |=> $countones(valid_reg) + 1 == $countones($past(valid_reg)))
        else $error("expired timer did not free exactly one slot");

    a_read_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        data_vld_reg |-> state_reg == dtq_pkg::ST_SCAN || state_reg == dtq_pkg::ST_TAIL)
        else $error("slot data returned outside a scan pass");

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking testbench for deadline_timer_queue_unit. A directed plan,
// then random schedule/check traffic, checked against a timer table tracker.
// Depends on dtq_pkg and the unit under test.

module tb_top;

    localparam logic [dtq_pkg::DL_W-1:0] DL_MAX = {dtq_pkg::DL_W{1'b1}};
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RAND_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        dtq_pkg::in_item_t  item;
        bit                 typed;
        dtq_pkg::out_item_t want;
    } plan_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    dtq_pkg::in_item_t  s_item  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    dtq_pkg::out_item_t m_item;

    // tracked copy of the timer table
    logic [dtq_pkg::DL_W-1:0]   tbl_deadline [dtq_pkg::TIMER_SLOTS];
    logic [dtq_pkg::TASK_W-1:0] tbl_handle   [dtq_pkg::TIMER_SLOTS];
    bit                         tbl_busy     [dtq_pkg::TIMER_SLOTS];

    dtq_pkg::out_item_t due_results[$];
    plan_row_t          plan[$];
    int                 err_cnt       = 0;
    int                 results_seen  = 0;
    int                 cycle_cnt     = 0;
    bit                 quiet_stretch = 1'b0;

    deadline_timer_queue_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [dtq_pkg::DL_W-1:0] rand_dl();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic int earliest_busy();
        int best;
        best = -1;
        for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++)
            if (tbl_busy[i] && (best < 0 || tbl_deadline[i] < tbl_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic bit any_busy();
        bit found;
        found = 1'b0;
        for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++)
            found |= tbl_busy[i];
        return found;
    endfunction

    // Apply one accepted item to the tracked table and queue the results it causes.
    task automatic predict_timer_results(input dtq_pkg::in_item_t it);
        dtq_pkg::out_item_t       r;
        logic [dtq_pkg::DL_W-1:0] d;
        int                       free_i, e, n;
        bit                       hit, dropped;
        if (it.operation == dtq_pkg::OP_SCHEDULE) begin
            d       = it.deadline_us;
            free_i  = -1;
            dropped = 1'b0;
            r       = '0;
            r.kind  = dtq_pkg::KIND_SCHED;
            r.last  = 1'b1;
            r.deadline_out = it.deadline_us;
            for (int i = dtq_pkg::TIMER_SLOTS - 1; i >= 0; i--)
                if (!tbl_busy[i])
                    free_i = i;
            if (free_i < 0) begin
                r.status  = dtq_pkg::STATUS_FULL;
                r.pending = any_busy();
            end else begin
                // bump past every deadline already held
                hit = 1'b1;
                n   = 0;
                while (hit && !dropped && n <= dtq_pkg::TIMER_SLOTS) begin
                    hit = 1'b0;
                    for (int j = 0; j < dtq_pkg::TIMER_SLOTS; j++)
                        if (tbl_busy[j] && tbl_deadline[j] == d)
                            hit = 1'b1;
                    if (hit) begin
                        if (d == DL_MAX)
                            dropped = 1'b1;
                        else
                            d = d + 1'b1;
                    end
                    n++;
                end
                if (dropped) begin
                    r.status  = dtq_pkg::STATUS_NOFREE;
                    r.pending = any_busy();
                end else begin
                    tbl_deadline[free_i] = d;
                    tbl_handle[free_i]   = it.task_handle;
                    tbl_busy[free_i]     = 1'b1;
                    r.status       = dtq_pkg::STATUS_OK;
                    r.deadline_out = d;
                    r.rearm        = (earliest_busy() == free_i);
                    r.pending      = 1'b1;
                end
            end
            due_results.push_back(r);
        end else begin
            e = earliest_busy();
            while (e >= 0 && tbl_deadline[e] <= it.now_us) begin
                tbl_busy[e]    = 1'b0;
                r              = '0;
                r.kind         = dtq_pkg::KIND_EXPIRE;
                r.task_out     = tbl_handle[e];
                r.deadline_out = tbl_deadline[e];
                r.pending      = any_busy();
                due_results.push_back(r);
                e = earliest_busy();
            end
            r      = '0;
            r.kind = dtq_pkg::KIND_CLOSE;
            r.last = 1'b1;
            if (e >= 0) begin
                r.deadline_out = tbl_deadline[e];
                r.rearm        = 1'b1;
                r.pending      = 1'b1;
            end
            due_results.push_back(r);
        end
    endtask

    // Hold valid until the item is taken, then predict.
    task automatic offer_item(input dtq_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_timer_results(it);
    endtask

    task automatic idle_sender();
        while (!quiet_stretch && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic dtq_pkg::in_item_t sched_req(logic [dtq_pkg::DL_W-1:0] dl,
                                                    logic [dtq_pkg::TASK_W-1:0] tk);
        dtq_pkg::in_item_t it;
        it.operation   = dtq_pkg::OP_SCHEDULE;
        it.deadline_us = dl;
        it.task_handle = tk;
        it.now_us      = rand_dl();
        return it;
    endfunction

    function automatic dtq_pkg::in_item_t check_req(logic [dtq_pkg::DL_W-1:0] now);
        dtq_pkg::in_item_t it;
        it.operation   = dtq_pkg::OP_CHECK;
        it.deadline_us = rand_dl();
        it.task_handle = 16'($urandom);
        it.now_us      = now;
        return it;
    endfunction

    function automatic dtq_pkg::out_item_t answer(logic [1:0] kind, logic [1:0] status,
                                                  logic [dtq_pkg::DL_W-1:0] dl,
                                                  logic rearm, logic pending);
        dtq_pkg::out_item_t r;
        r              = '0;
        r.kind         = kind;
        r.status       = status;
        r.deadline_out = dl;
        r.rearm        = rearm;
        r.pending      = pending;
        r.last         = 1'b1;
        return r;
    endfunction

    task automatic add_row(input dtq_pkg::in_item_t it, input bit typed,
                           input dtq_pkg::out_item_t want);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Stimulus
    initial begin
        logic [dtq_pkg::DL_W-1:0] clock_now;
        logic [dtq_pkg::DL_W-1:0] dl;
        int                       pick;

        add_row(check_req('0), 1'b1,
                answer(dtq_pkg::KIND_CLOSE, dtq_pkg::STATUS_OK, '0, 1'b0, 1'b0));
        add_row(sched_req(48'd100, 16'h0001), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_OK, 48'd100, 1'b1, 1'b1));
        add_row(sched_req(48'd100, 16'h0002), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_OK, 48'd101, 1'b0, 1'b1));
        add_row(sched_req(48'd100, 16'h0003), 1'b0, '0);
        add_row(sched_req(DL_MAX, 16'hFFFF), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_OK, DL_MAX, 1'b0, 1'b1));
        add_row(sched_req(DL_MAX, 16'h0004), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_NOFREE, DL_MAX, 1'b0, 1'b1));
        add_row(sched_req(DL_MAX - 1, 16'h0005), 1'b0, '0);
        // collides, bumps into the maximum, then drops
        add_row(sched_req(DL_MAX - 1, 16'h0006), 1'b0, '0);
        add_row(sched_req('0, 16'h0000), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_OK, '0, 1'b1, 1'b1));
        add_row(check_req(48'd101), 1'b0, '0);
        // fill the remaining slots
        for (int i = 0; i < dtq_pkg::TIMER_SLOTS - 3; i++)
            add_row(sched_req(48'h5555_0000_0000 + 48'(i % 4), 16'hAAAA ^ 16'(i)),
                    1'b0, '0);
        add_row(sched_req(48'hAAAA_AAAA_AAAA, 16'h5555), 1'b1,
                answer(dtq_pkg::KIND_SCHED, dtq_pkg::STATUS_FULL, 48'hAAAA_AAAA_AAAA,
                       1'b0, 1'b1));
        add_row(check_req(DL_MAX), 1'b0, '0);
        add_row(check_req('0), 1'b1,
                answer(dtq_pkg::KIND_CLOSE, dtq_pkg::STATUS_OK, '0, 1'b0, 1'b0));

        for (int i = 0; i < dtq_pkg::TIMER_SLOTS; i++)
            tbl_busy[i] = 1'b0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            offer_item(plan[i].item);
            if (plan[i].typed) begin
                void'(due_results.pop_back());
                due_results.push_back(plan[i].want);
            end
            idle_sender();
        end

        clock_now = 48'($urandom);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet_stretch = (n >= 60 && n < 130);
            if (n == 200) begin
                // let the unit drain completely
                s_valid <= 1'b0;
                while (due_results.size() != 0)
                    @(posedge aclk);
            end
            pick = $urandom_range(99);
            if (pick < 55) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    dl = clock_now + 48'($urandom_range(40));
                else if (pick < 75)
                    dl = clock_now + 48'($urandom_range(3));
                else if (pick < 88)
                    dl = DL_MAX - 48'($urandom_range(3));
                else
                    dl = rand_dl();
                offer_item(sched_req(dl, 16'($urandom)));
            end else begin
                pick = $urandom_range(99);
                clock_now = clock_now + 48'($urandom_range(30));
                if (pick < 80)
                    dl = clock_now;
                else if (pick < 88)
                    dl = clock_now - 48'($urandom_range(20));
                else if (pick < 96)
                    dl = rand_dl();
                else
                    dl = DL_MAX;
                offer_item(check_req(dl));
            end
            idle_sender();
        end

        s_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: check each accepted result, then pick the next ready level.
    initial begin
        dtq_pkg::out_item_t exp_r;
        int                 hold_left;
        bit                 held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result: kind %0d status %0d task %h dl %h",
                                 m_item.kind, m_item.status, m_item.task_out,
                                 m_item.deadline_out);
                end else begin
                    exp_r = due_results.pop_front();
                    if (m_item.kind !== exp_r.kind || m_item.status !== exp_r.status ||
                        m_item.task_out !== exp_r.task_out ||
                        m_item.deadline_out !== exp_r.deadline_out ||
                        m_item.rearm !== exp_r.rearm || m_item.pending !== exp_r.pending ||
                        m_item.last !== exp_r.last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $write("mismatch at result %0d (exp/got): kind %0d/%0d ",
                                   results_seen, exp_r.kind, m_item.kind);
                            $write("status %0d/%0d task %h/%h dl %h/%h ",
                                   exp_r.status, m_item.status,
                                   exp_r.task_out, m_item.task_out,
                                   exp_r.deadline_out, m_item.deadline_out);
                            $display("rearm %b/%b pending %b/%b last %b/%b",
                                     exp_r.rearm, m_item.rearm,
                                     exp_r.pending, m_item.pending,
                                     exp_r.last, m_item.last);
                        end
                    end
                end
            end
            // one long hold-off while the sender keeps offering
            if (!held && results_seen >= 150) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!aresetn)
                m_ready <= 1'b0;
            else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet_stretch)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= 22);
        end
    end

endmodule
